### src/encal_pkg.sv
package encal_pkg;

    localparam int DIV_W    = 64;
    localparam int REM_W    = 30;
    localparam int DIV_STEP = 4;
    localparam int CNT_W    = 5;

    localparam logic [1:0] CFG_ZONE = 2'd0;
    localparam logic [1:0] CFG_DST  = 2'd1;

    typedef enum logic [2:0] {
        OP_SEC,
        OP_US,
        OP_MS,
        OP_DAY,
        OP_HOUR,
        OP_MIN,
        OP_WDAY
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_GO,
        S_DIV_WAIT,
        S_YEAR,
        S_MONTH,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic div_go;
        t_op  op;
        logic year_step;
        logic month_calc;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic year_done;
        logic out_free;
    } t_sts;

    // first day (zero based) of each month in a common year
    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] d;
        begin
            unique case (m)
                4'd0:    d = 9'd0;
                4'd1:    d = 9'd31;
                4'd2:    d = 9'd59;
                4'd3:    d = 9'd90;
                4'd4:    d = 9'd120;
                4'd5:    d = 9'd151;
                4'd6:    d = 9'd181;
                4'd7:    d = 9'd212;
                4'd8:    d = 9'd243;
                4'd9:    d = 9'd273;
                4'd10:   d = 9'd304;
                4'd11:   d = 9'd334;
                default: d = 9'd0;
            endcase
            return d;
        end
    endfunction

endpackage

### src/encal_div.sv
module encal_div
    import encal_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_num,
    input  logic [REM_W-1:0] i_den,
    input  logic [CNT_W-1:0] i_cycles,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quo,
    output logic [REM_W-1:0] o_rem
);

    logic [DIV_W-1:0] r_num, n_num;
    logic [REM_W-1:0] r_rem, n_rem;
    logic [REM_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;

    // restoring division, DIV_STEP quotient bits per cycle
    always_comb begin
        logic [REM_W:0] trial;
        n_num = r_num;
        n_rem = r_rem;
        for (int k = 0; k < DIV_STEP; k++) begin
            trial = {n_rem, n_num[DIV_W-1]};
            n_num = {n_num[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, r_den}) begin
                n_rem    = REM_W'(trial - {1'b0, r_den});
                n_num[0] = 1'b1;
            end else begin
                n_rem = trial[REM_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= i_cycles;
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_num <= n_num;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_num;
    assign o_rem  = r_rem;

endmodule

### src/encal_dp.sv
module encal_dp
    import encal_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic [62:0] i_stamp_ns,
    input  logic        i_cfg_valid,
    input  logic [1:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic [11:0] o_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day_of_month,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic [5:0]  o_second,
    output logic [2:0]  o_weekday,
    output logic [8:0]  o_day_of_year,
    output logic [9:0]  o_millis,
    output logic [9:0]  o_micros,
    output logic        o_dst_flag,
    output logic        o_clamped
);

    logic [16:0] r_zone;
    logic        r_dst;

    logic [62:0] r_stamp;
    logic [33:0] r_secs;
    logic [29:0] r_frac;
    logic [19:0] r_us;
    logic [9:0]  r_ms, r_mic;
    logic [16:0] r_days, r_sod;
    logic [4:0]  r_hour;
    logic [11:0] r_hrem;
    logic [5:0]  r_min, r_sec;
    logic [2:0]  r_wday;
    logic [11:0] r_year;
    logic [16:0] r_yday;
    logic [6:0]  r_c100;
    logic [8:0]  r_c400;
    logic        r_clamp, r_dst_used;
    logic [3:0]  r_month;
    logic [4:0]  r_dom;
    logic        r_out_valid;

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone <= '0;
            r_dst  <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ZONE: r_zone <= i_cfg_data;
                CFG_DST:  r_dst  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // local seconds, clamped at the epoch
    logic signed [35:0] adj;
    logic        [33:0] t_loc;
    assign adj = $signed({2'b00, r_secs}) - $signed({{19{r_zone[16]}}, r_zone})
                 + (r_dst ? 36'sd3600 : 36'sd0);
    assign t_loc = adj[35] ? 34'd0 : adj[33:0];

    logic [17:0] wsum;
    assign wsum = {1'b0, r_days} + 18'd4;

    // divider operands, dividend left aligned
    logic [DIV_W-1:0] d_num;
    logic [REM_W-1:0] d_den;
    logic [CNT_W-1:0] d_cyc;
    always_comb begin
        case (i_cmd.op)
            OP_SEC: begin
                d_num = {1'b0, r_stamp};
                d_den = REM_W'(1000000000);
                d_cyc = CNT_W'(16);
            end
            OP_US: begin
                d_num = {2'b00, r_frac, 32'd0};
                d_den = REM_W'(1000);
                d_cyc = CNT_W'(8);
            end
            OP_MS: begin
                d_num = {r_us, 44'd0};
                d_den = REM_W'(1000);
                d_cyc = CNT_W'(5);
            end
            OP_DAY: begin
                d_num = {2'b00, t_loc, 28'd0};
                d_den = REM_W'(86400);
                d_cyc = CNT_W'(9);
            end
            OP_HOUR: begin
                d_num = {3'b000, r_sod, 44'd0};
                d_den = REM_W'(3600);
                d_cyc = CNT_W'(5);
            end
            OP_MIN: begin
                d_num = {r_hrem, 52'd0};
                d_den = REM_W'(60);
                d_cyc = CNT_W'(3);
            end
            OP_WDAY: begin
                d_num = {2'b00, wsum, 44'd0};
                d_den = REM_W'(7);
                d_cyc = CNT_W'(5);
            end
            default: begin
                d_num = '0;
                d_den = REM_W'(1);
                d_cyc = '0;
            end
        endcase
    end

    logic             div_done;
    logic [DIV_W-1:0] quo;
    logic [REM_W-1:0] rem;

    encal_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.div_go),
        .i_num    (d_num),
        .i_den    (d_den),
        .i_cycles (d_cyc),
        .o_done   (div_done),
        .o_quo    (quo),
        .o_rem    (rem)
    );

    // year walk: 100, 4 or 1 year a cycle
    logic        leap;
    logic [16:0] len1, len4, len100;
    logic        can100, can4, can1;
    assign leap   = ((r_year[1:0] == 2'd0) && (r_c100 != 7'd0)) || (r_c400 == 9'd0);
    assign len1   = 17'd365 + {16'd0, leap};
    assign len4   = 17'd1460 + {16'd0, leap};
    assign len100 = 17'd36524 + {16'd0, (r_c400 == 9'd0)};
    assign can100 = (r_c100 == 7'd0) && (r_yday >= len100);
    assign can4   = (r_year[1:0] == 2'd0) && (r_yday >= len4);
    assign can1   = r_yday >= len1;

    // month from start-of-month table
    logic [3:0] mon;
    logic [8:0] mstart;
    always_comb begin
        mon = 4'd0;
        for (int m = 1; m < 12; m++) begin
            if (r_yday >= 17'(month_start(4'(m))) + ((m >= 2) ? {16'd0, leap} : 17'd0)) begin
                mon = 4'(m);
            end
        end
        mstart = month_start(mon) + ((mon >= 4'd2) ? {8'd0, leap} : 9'd0);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_stamp <= i_stamp_ns;
        end
        if (i_cmd.div_go && (i_cmd.op == OP_DAY)) begin
            r_clamp    <= adj[35];
            r_dst_used <= r_dst;
        end
        if (div_done) begin
            case (i_cmd.op)
                OP_SEC: begin
                    r_secs <= quo[33:0];
                    r_frac <= rem;
                end
                OP_US: r_us <= quo[19:0];
                OP_MS: begin
                    r_ms  <= quo[9:0];
                    r_mic <= rem[9:0];
                end
                OP_DAY: begin
                    r_days <= quo[16:0];
                    r_sod  <= rem[16:0];
                    r_yday <= quo[16:0];
                    r_year <= 12'd1970;
                    r_c100 <= 7'd70;
                    r_c400 <= 9'd370;
                end
                OP_HOUR: begin
                    r_hour <= quo[4:0];
                    r_hrem <= rem[11:0];
                end
                OP_MIN: begin
                    r_min <= quo[5:0];
                    r_sec <= rem[5:0];
                end
                OP_WDAY: r_wday <= rem[2:0];
                default: ;
            endcase
        end
        if (i_cmd.year_step) begin
            if (can100) begin
                r_yday <= r_yday - len100;
                r_year <= r_year + 12'd100;
                r_c400 <= (r_c400 >= 9'd300) ? r_c400 - 9'd300 : r_c400 + 9'd100;
            end else if (can4) begin
                r_yday <= r_yday - len4;
                r_year <= r_year + 12'd4;
                r_c100 <= (r_c100 == 7'd96) ? 7'd0 : r_c100 + 7'd4;
                r_c400 <= (r_c400 == 9'd396) ? 9'd0 : r_c400 + 9'd4;
            end else if (can1) begin
                r_yday <= r_yday - len1;
                r_year <= r_year + 12'd1;
                r_c100 <= (r_c100 == 7'd99) ? 7'd0 : r_c100 + 7'd1;
                r_c400 <= (r_c400 == 9'd399) ? 9'd0 : r_c400 + 9'd1;
            end
        end
        if (i_cmd.month_calc) begin
            r_month <= mon + 4'd1;
            r_dom   <= 5'(r_yday - {8'd0, mstart} + 17'd1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_year         <= r_year;
            o_month        <= r_month;
            o_day_of_month <= r_dom;
            o_hour         <= r_hour;
            o_minute       <= r_min;
            o_second       <= r_sec;
            o_weekday      <= r_wday;
            o_day_of_year  <= r_yday[8:0];
            o_millis       <= r_ms;
            o_micros       <= r_mic;
            o_dst_flag     <= r_dst_used;
            o_clamped      <= r_clamp;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_sts.div_done  = div_done;
    assign o_sts.year_done = !(can100 || can4 || can1);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

endmodule

### src/encal_ctrl.sv
module encal_ctrl
    import encal_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    t_op    r_op, n_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_SEC;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DIV_GO;
                    n_op    = OP_SEC;
                end
            end
            S_DIV_GO: n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = S_DIV_GO;
                    unique case (r_op)
                        OP_SEC:  n_op = OP_US;
                        OP_US:   n_op = OP_MS;
                        OP_MS:   n_op = OP_DAY;
                        OP_DAY:  n_op = OP_HOUR;
                        OP_HOUR: n_op = OP_MIN;
                        OP_MIN:  n_op = OP_WDAY;
                        default: n_state = S_YEAR;
                    endcase
                end
            end
            S_YEAR: begin
                if (i_sts.year_done) begin
                    n_state = S_MONTH;
                end
            end
            S_MONTH: n_state = S_FINISH;
            S_FINISH: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.op         = r_op;
        o_in_ready       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_DIV_GO:   o_cmd.div_go     = 1'b1;
            S_DIV_WAIT: ;
            S_YEAR:     o_cmd.year_step  = !i_sts.year_done;
            S_MONTH:    o_cmd.month_calc = 1'b1;
            S_FINISH:   o_cmd.out_load   = i_sts.out_free;
            default: ;
        endcase
    end

endmodule

### src/epoch_ns_to_local_calendar.sv
// One item in flight from input beat to result.
// Seven divisions run on one shared radix-16 divider (the ns split first, then the rest,
// each with a start state and a wait state), then the year walk steps by 100, 4 or 1
// years at a time, then the month is found and the result is loaded.
// A new input beat is taken once the previous result sits in the output register.
// Reset (synchronous, active low) clears control, zone offset and summer time.
module epoch_ns_to_local_calendar
    import encal_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [62:0] i_stamp_ns,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [11:0] o_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day_of_month,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic [5:0]  o_second,
    output logic [2:0]  o_weekday,
    output logic [8:0]  o_day_of_year,
    output logic [9:0]  o_millis,
    output logic [9:0]  o_micros,
    output logic        o_dst_flag,
    output logic        o_clamped,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    encal_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    encal_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_stamp_ns     (i_stamp_ns),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_year         (o_year),
        .o_month        (o_month),
        .o_day_of_month (o_day_of_month),
        .o_hour         (o_hour),
        .o_minute       (o_minute),
        .o_second       (o_second),
        .o_weekday      (o_weekday),
        .o_day_of_year  (o_day_of_year),
        .o_millis       (o_millis),
        .o_micros       (o_micros),
        .o_dst_flag     (o_dst_flag),
        .o_clamped      (o_clamped)
    );

`ifndef SYNTH
    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while busy");

    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_month >= 4'd1 && o_month <= 4'd12 && o_day_of_month >= 5'd1)
        else $error("month or day out of range");

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_weekday <= 3'd6 && o_hour <= 5'd23 && o_minute <= 6'd59
                        && o_second <= 6'd59)
        else $error("time of day out of range");

    a_clamp_epoch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_clamped |-> o_year == 12'd1970 && o_day_of_year == 9'd0)
        else $error("clamped result not at epoch");
`endif

endmodule

### tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import encal_pkg::*;

    localparam logic [1:0] CFG_NONE = 2'd3;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  mday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  wday;
        logic [8:0]  yday;
        logic [9:0]  millis;
        logic [9:0]  micros;
        logic        dst;
        logic        clamped;
    } t_cal;

    typedef struct {
        logic [62:0] stamp;
        bit          typed;
        t_cal        cal;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [62:0] i_stamp_ns = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = CFG_ZONE;
    logic [16:0] i_cfg_data = '0;
    t_cal        got;

    logic [16:0] zone_west = '0;
    logic        summer = 1'b0;
    t_cal        pending_cal[$];
    int          n_bad = 0;
    bit          hold_req = 0;
    bit          hold_done = 0;
    int          hold_left = 0;
    bit          stall_on = 1;

    epoch_ns_to_local_calendar uut (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .i_stamp_ns,
        .o_out_valid, .i_out_ready,
        .o_year(got.year), .o_month(got.month), .o_day_of_month(got.mday),
        .o_hour(got.hour), .o_minute(got.minute), .o_second(got.second),
        .o_weekday(got.wday), .o_day_of_year(got.yday), .o_millis(got.millis),
        .o_micros(got.micros), .o_dst_flag(got.dst), .o_clamped(got.clamped),
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #80ms;
        $display("== FAIL ==");
        $finish;
    end

    function automatic bit is_leap(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic t_cal civil_of(input logic [62:0] stamp);
        t_cal c;
        longint unsigned secs, frac, t, days, sod, dd;
        longint adj;
        int unsigned y, m, ml;
        begin
            secs = stamp / 64'd1000000000;
            frac = stamp % 64'd1000000000;
            adj = longint'(secs) - longint'($signed(zone_west)) + (summer ? 3600 : 0);
            c.clamped = adj < 0;
            if (adj < 0)
                adj = 0;
            t = adj;
            days = t / 86400;
            sod = t % 86400;
            y = 1970;
            dd = days;
            while (dd >= 365 + is_leap(y)) begin
                dd -= 365 + is_leap(y);
                y++;
            end
            c.yday = 9'(dd);
            m = 0;
            while (m < 11) begin
                ml = (m == 1) ? 28 + is_leap(y) : (m == 3 || m == 5 || m == 8 || m == 10) ? 30 : 31;
                if (dd < ml)
                    break;
                dd -= ml;
                m++;
            end
            c.year = 12'(y);
            c.month = 4'(m + 1);
            c.mday = 5'(dd + 1);
            c.hour = 5'(sod / 3600);
            c.minute = 6'((sod % 3600) / 60);
            c.second = 6'(sod % 60);
            c.wday = 3'((days + 4) % 7);
            c.millis = 10'((frac / 1000) / 1000);
            c.micros = 10'((frac / 1000) % 1000);
            c.dst = summer;
            return c;
        end
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [16:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_ZONE)
            zone_west = val;
        else if (idx == CFG_DST)
            summer = val[0];
        @(posedge i_clk);
    endtask

    // valid stays high after the beat; the caller drops it before a gap
    task automatic send_stamp(input logic [62:0] s, input bit typed, input t_cal c);
        i_in_valid <= 1'b1;
        i_stamp_ns <= s;
        do @(posedge i_clk); while (!o_in_ready);
        pending_cal.push_back(typed ? c : civil_of(s));
    endtask

    task automatic drain();
        int n;
        n = 0;
        while (pending_cal.size() != 0 && n < 200000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (120) @(posedge i_clk);
    endtask

    function automatic logic [62:0] rand_stamp();
        logic [62:0] s;
        case ($urandom_range(0, 5))
            0: s = 63'({$urandom, $urandom});
            1: s = 63'(longint'($urandom_range(0, 200000)) * 64'd1000000000
                       + 64'($urandom_range(0, 999999999)));
            2: s = 63'({$urandom, $urandom} % 64'd9223372036854775807 + 64'd1);
            3: s = 63'h7FFFFFFFFFFFFFFF - 63'($urandom_range(0, 1 << 30));
            default: s = 63'({$urandom_range(0, 1 << 30), $urandom} * 64'd4);
        endcase
        return s;
    endfunction

    // receiver: own stall pattern, plus one long hold-off counted here
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            i_out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            i_out_ready <= 1'b0;
            hold_left <= 300;
            hold_done <= 1'b1;
        end else if (stall_on)
            i_out_ready <= ($urandom_range(0, 3) != 0);
        else
            i_out_ready <= 1'b1;
    end

    always @(posedge i_clk) begin
        t_cal want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_cal.size() == 0) begin
                $error("result beat with nothing expected");
                n_bad++;
            end else begin
                want = pending_cal.pop_front();
                if (got.year !== want.year) begin
                    $error("year exp %0d got %0d", want.year, got.year); n_bad++;
                end
                if (got.month !== want.month) begin
                    $error("month exp %0d got %0d", want.month, got.month); n_bad++;
                end
                if (got.mday !== want.mday) begin
                    $error("day_of_month exp %0d got %0d", want.mday, got.mday); n_bad++;
                end
                if (got.hour !== want.hour) begin
                    $error("hour exp %0d got %0d", want.hour, got.hour); n_bad++;
                end
                if (got.minute !== want.minute) begin
                    $error("minute exp %0d got %0d", want.minute, got.minute); n_bad++;
                end
                if (got.second !== want.second) begin
                    $error("second exp %0d got %0d", want.second, got.second); n_bad++;
                end
                if (got.wday !== want.wday) begin
                    $error("weekday exp %0d got %0d", want.wday, got.wday); n_bad++;
                end
                if (got.yday !== want.yday) begin
                    $error("day_of_year exp %0d got %0d", want.yday, got.yday); n_bad++;
                end
                if (got.millis !== want.millis) begin
                    $error("millis exp %0d got %0d", want.millis, got.millis); n_bad++;
                end
                if (got.micros !== want.micros) begin
                    $error("micros exp %0d got %0d", want.micros, got.micros); n_bad++;
                end
                if (got.dst !== want.dst) begin
                    $error("dst_flag exp %0d got %0d", want.dst, got.dst); n_bad++;
                end
                if (got.clamped !== want.clamped) begin
                    $error("clamped exp %0d got %0d", want.clamped, got.clamped); n_bad++;
                end
            end
        end
    end

    initial begin
        t_row dir_rows[$];
        t_cal z;
        logic [16:0] zones[6];
        int ph, k, burst, gap;
        z = '0;
        zones = '{17'h10000, 17'(-50400), 17'd43200, 17'h0FFFF,
                  17'(-3600), 17'd18000};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: epoch, extremes, leap days, field bits
        z = '{year: 1970, month: 1, mday: 1, wday: 4, default: '0};
        dir_rows.push_back('{63'd0, 1, z});
        z.millis = 999; z.micros = 999;
        dir_rows.push_back('{63'd999999999, 1, z});
        dir_rows.push_back('{63'h7FFFFFFFFFFFFFFF, 0, z});
        dir_rows.push_back('{63'd951782400000000000, 0, z});   // 2000-02-29
        dir_rows.push_back('{63'd4107542399000000000, 0, z});  // last second of Feb 2100
        dir_rows.push_back('{63'd5097600000000000000, 0, z});
        dir_rows.push_back('{63'd68169600000000000, 0, z});    // leap 1972 Feb 29
        dir_rows.push_back('{63'd1234567890123456789, 0, z});
        dir_rows.push_back('{63'h5555555555555555, 0, z});
        dir_rows.push_back('{63'h2AAAAAAAAAAAAAAA, 0, z});
        dir_rows.push_back('{63'd86399999999999, 0, z});
        dir_rows.push_back('{63'd31535999000000000, 0, z});
        foreach (dir_rows[i])
            send_stamp(dir_rows[i].stamp, dir_rows[i].typed, dir_rows[i].cal);
        i_in_valid <= 1'b0;
        drain();

        // clamp with a positive offset west
        write_reg(CFG_ZONE, 17'd43200);
        write_reg(CFG_DST, 17'd1);
        z = '{year: 1970, month: 1, mday: 1, wday: 4, dst: 1, clamped: 1, default: '0};
        send_stamp(63'd0, 1, z);
        send_stamp(63'd39599000000000, 0, z);
        send_stamp(63'd39600000000000, 0, z);
        i_in_valid <= 1'b0;
        drain();
        write_reg(CFG_NONE, 17'h1FFFF);  // unlisted index, ignored
        send_stamp(63'd0, 0, z);
        i_in_valid <= 1'b0;
        drain();

        for (ph = 0; ph < 6; ph++) begin
            write_reg(CFG_ZONE, zones[ph]);
            write_reg(CFG_DST, {16'd0, ph[0]});
            stall_on = (ph != 2);
            k = 0;
            while (k < 270) begin
                burst = $urandom_range(1, 12);
                repeat (burst) begin
                    send_stamp(rand_stamp(), 0, z);
                    k++;
                end
                i_in_valid <= 1'b0;
                // receiver holds off while the sender keeps offering beats
                if (ph == 4 && k > 100 && k < 115)
                    hold_req = 1'b1;
                if (ph == 3 && k > 100 && k < 115)
                    while (pending_cal.size() != 0) @(posedge i_clk);
                gap = $urandom_range(0, 1) ? 1 : $urandom_range(1, 150);
                repeat (gap) @(posedge i_clk);
            end
            drain();
        end

        if (n_bad == 0 && pending_cal.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
